// ===== rtl/rra_pkg.sv =====
// ----------------------------------------------------------------------------
// rra_pkg: shared types and constants for the rounded-rectangle fill core
// Field widths, register indexes, reset values and the per-channel blend.
// ----------------------------------------------------------------------------
package rra_pkg;

   // coordinate width default, range 10 to 16
   localparam int COORD_BITS_DEF = 10;

   // register field widths
   localparam int EDGE_BITS   = 11;
   localparam int SIZE_BITS   = 10;
   localparam int RADIUS_BITS = 9;
   localparam int SQ_BITS     = 2 * RADIUS_BITS;
   localparam int PROD_BITS   = 2 * SQ_BITS;

   // color channels
   localparam int              CH_BITS   = 8;
   localparam int              RGBA_BITS = 4 * CH_BITS;
   localparam logic [CH_BITS-1:0] CH_MAX = 8'hFF;

   // register port
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = RGBA_BITS;

   localparam logic [RGBA_BITS-1:0] FILL_RESET = 32'hFF00_0000;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_RECT_LEFT   = 3'd0,
      CSR_RECT_TOP    = 3'd1,
      CSR_RECT_WIDTH  = 3'd2,
      CSR_RECT_HEIGHT = 3'd3,
      CSR_CORNER_RX   = 3'd4,
      CSR_CORNER_RY   = 3'd5,
      CSR_FILL_RGBA   = 3'd6
   } csr_idx_type;

   // (a*fg + (255-a)*old) >> 8, fits 16 bits before the shift
   function automatic logic [CH_BITS-1:0] blend8(input logic [CH_BITS-1:0] a,
                                                 input logic [CH_BITS-1:0] fg,
                                                 input logic [CH_BITS-1:0] old);
      logic [2*CH_BITS-1:0] sum;
      sum = (2*CH_BITS)'(a) * (2*CH_BITS)'(fg)
          + (2*CH_BITS)'(CH_MAX - a) * (2*CH_BITS)'(old);
      return sum[2*CH_BITS-1:CH_BITS];
   endfunction

endpackage

// ===== rtl/rounded_rect_alpha_fill_core.sv =====
// ----------------------------------------------------------------------------
// rounded_rect_alpha_fill_core: rounded-rectangle overlay with alpha blend
// Judges each framebuffer pixel against a rectangle with elliptic corners
// and replaces or blends the inside pixels with the fill color.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                beat
//  req_*     in         req_valid / req_stall    pix_x, pix_y, old_r/g/b/a
//  rsp_*     out        rsp_valid / rsp_stall    new_r/g/b/a, written
//  csr_*     in         csr_wr_en                csr_index, csr_wdata
//
//  One pixel per clock sustained while rsp_stall is low.
//  Most stages belong to the corner search: two stages per radius bit
//  (candidate square, then multiply and compare), nine bits.
//  Reset clears all stage valid bits and loads the register defaults.
//  Stall: each stage holds only when it is full and the one after it holds,
//  so empty stages keep taking beats while a result waits on rsp_stall.
// ----------------------------------------------------------------------------
module rounded_rect_alpha_fill_core #(
   parameter int COORD_BITS = rra_pkg::COORD_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // pixel input
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [COORD_BITS-1:0]            req_pix_x,
   input  logic [COORD_BITS-1:0]            req_pix_y,
   input  logic [rra_pkg::CH_BITS-1:0]      req_old_r,
   input  logic [rra_pkg::CH_BITS-1:0]      req_old_g,
   input  logic [rra_pkg::CH_BITS-1:0]      req_old_b,
   input  logic [rra_pkg::CH_BITS-1:0]      req_old_a,
   // pixel result
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [rra_pkg::CH_BITS-1:0]      rsp_new_r,
   output logic [rra_pkg::CH_BITS-1:0]      rsp_new_g,
   output logic [rra_pkg::CH_BITS-1:0]      rsp_new_b,
   output logic [rra_pkg::CH_BITS-1:0]      rsp_new_a,
   output logic                             rsp_written,
   // register writes
   input  logic                             csr_wr_en,
   input  logic [rra_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [rra_pkg::CSR_DATA_BITS-1:0] csr_wdata
);
   import rra_pkg::*;

   // signed offset from the rectangle edge
   localparam int DW = COORD_BITS + 2;

   // stage map
   localparam int S_IN    = 0;   // offsets from the edges
   localparam int S_CLAMP = 1;   // radius clamp, range checks
   localparam int S_BAND  = 2;   // corner band, row distance
   localparam int S_SQR   = 3;   // squares
   localparam int S_DIFF  = 4;   // ry^2 - dy^2
   localparam int S_T     = 5;   // bound rx^2 * (ry^2 - dy^2)
   localparam int S_SRCH  = 6;   // two stages per radius bit
   localparam int S_INS   = S_SRCH + 2 * RADIUS_BITS;
   localparam int S_OUT   = S_INS + 1;
   localparam int NSTG    = S_OUT + 1;

   typedef struct packed {
      logic [CH_BITS-1:0]     col_r;
      logic [CH_BITS-1:0]     col_g;
      logic [CH_BITS-1:0]     col_b;
      logic [CH_BITS-1:0]     col_a;
      logic [DW-1:0]          xx;
      logic [DW-1:0]          yy;
      logic [SIZE_BITS-1:0]   xl;
      logic [SIZE_BITS-1:0]   yl;
      logic                   x_ok;
      logic                   y_ok;
      logic                   band;
      logic [RADIUS_BITS-1:0] rxc;
      logic [RADIUS_BITS-1:0] ryc;
      logic [RADIUS_BITS-1:0] dy;
      logic [RADIUS_BITS-1:0] d;
      logic [RADIUS_BITS-1:0] c;
      logic [SQ_BITS-1:0]     rx2;
      logic [SQ_BITS-1:0]     ry2;
      logic [SQ_BITS-1:0]     dy2;
      logic [SQ_BITS-1:0]     diff;
      logic [SQ_BITS-1:0]     d2;
      logic [SQ_BITS-1:0]     c2;
      logic [PROD_BITS-1:0]   t;
      logic                   in_shape;
      logic                   written;
   } stage_type;

   // configuration registers
   logic [EDGE_BITS-1:0]   rect_left_ff;
   logic [EDGE_BITS-1:0]   rect_top_ff;
   logic [SIZE_BITS-1:0]   rect_width_ff;
   logic [SIZE_BITS-1:0]   rect_height_ff;
   logic [RADIUS_BITS-1:0] corner_rx_ff;
   logic [RADIUS_BITS-1:0] corner_ry_ff;
   logic [RGBA_BITS-1:0]   fill_rgba_ff;

   logic [CH_BITS-1:0]     fill_r;
   logic [CH_BITS-1:0]     fill_g;
   logic [CH_BITS-1:0]     fill_b;
   logic [CH_BITS-1:0]     fill_a;

   stage_type              pipe_ff [NSTG];
   stage_type              pipe_in [NSTG];
   logic [NSTG-1:0]        vld_ff;
   logic [NSTG-1:0]        vld_in;
   logic [NSTG-1:0]        adv;

   assign fill_r = fill_rgba_ff[CH_BITS-1:0];
   assign fill_g = fill_rgba_ff[2*CH_BITS-1:CH_BITS];
   assign fill_b = fill_rgba_ff[3*CH_BITS-1:2*CH_BITS];
   assign fill_a = fill_rgba_ff[4*CH_BITS-1:3*CH_BITS];

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         rect_left_ff   <= '0;
         rect_top_ff    <= '0;
         rect_width_ff  <= '0;
         rect_height_ff <= '0;
         corner_rx_ff   <= '0;
         corner_ry_ff   <= '0;
         fill_rgba_ff   <= FILL_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_idx_type'(csr_index))
            CSR_RECT_LEFT:   rect_left_ff   <= csr_wdata[EDGE_BITS-1:0];
            CSR_RECT_TOP:    rect_top_ff    <= csr_wdata[EDGE_BITS-1:0];
            CSR_RECT_WIDTH:  rect_width_ff  <= csr_wdata[SIZE_BITS-1:0];
            CSR_RECT_HEIGHT: rect_height_ff <= csr_wdata[SIZE_BITS-1:0];
            CSR_CORNER_RX:   corner_rx_ff   <= csr_wdata[RADIUS_BITS-1:0];
            CSR_CORNER_RY:   corner_ry_ff   <= csr_wdata[RADIUS_BITS-1:0];
            CSR_FILL_RGBA:   fill_rgba_ff   <= csr_wdata[RGBA_BITS-1:0];
            default: ;
         endcase
      end
   end

   // stage advance: a stage moves when it is empty or the next one moves
   assign adv[NSTG-1] = !vld_ff[NSTG-1] || !rsp_stall;
   for (genvar i = 0; i < NSTG - 1; i++) begin : g_adv
      assign adv[i] = !vld_ff[i] || adv[i+1];
   end

   assign vld_in = {vld_ff[NSTG-2:0], req_valid};
   assign req_stall = !adv[0];

   // next-stage logic, one section per stage
   always_comb begin
      stage_type              s;
      logic [SIZE_BITS-1:0]   half_w;
      logic [SIZE_BITS-1:0]   half_h;
      logic [SIZE_BITS-1:0]   hmr;
      logic [SIZE_BITS-1:0]   ry_w;
      logic [SIZE_BITS-1:0]   rim;
      logic                   top;
      logic                   bot;
      logic [RADIUS_BITS-1:0] ins;
      int                     sp;

      // offsets from the left and top edges
      s       = '0;
      s.col_r = req_old_r;
      s.col_g = req_old_g;
      s.col_b = req_old_b;
      s.col_a = req_old_a;
      s.xx    = DW'(req_pix_x)
              - {{(DW-EDGE_BITS){rect_left_ff[EDGE_BITS-1]}}, rect_left_ff};
      s.yy    = DW'(req_pix_y)
              - {{(DW-EDGE_BITS){rect_top_ff[EDGE_BITS-1]}}, rect_top_ff};
      pipe_in[S_IN] = s;

      // clamp radii to half size, range checks on both axes
      s      = pipe_ff[S_IN];
      half_w = {1'b0, rect_width_ff[SIZE_BITS-1:1]};
      half_h = {1'b0, rect_height_ff[SIZE_BITS-1:1]};
      s.rxc  = (SIZE_BITS'(corner_rx_ff) > half_w) ? RADIUS_BITS'(half_w) : corner_rx_ff;
      s.ryc  = (SIZE_BITS'(corner_ry_ff) > half_h) ? RADIUS_BITS'(half_h) : corner_ry_ff;
      s.x_ok = !s.xx[DW-1] && ($signed(s.xx) < $signed(DW'(rect_width_ff)));
      s.y_ok = !s.yy[DW-1] && ($signed(s.yy) < $signed(DW'(rect_height_ff)));
      s.xl   = s.xx[SIZE_BITS-1:0];
      s.yl   = s.yy[SIZE_BITS-1:0];
      pipe_in[S_CLAMP] = s;

      // rows within ry of the top or bottom edge, and their distance dy
      s    = pipe_ff[S_CLAMP];
      ry_w = SIZE_BITS'(s.ryc);
      hmr  = rect_height_ff - ry_w;
      top  = s.yl < ry_w;
      bot  = s.yl >= hmr;
      rim  = '0;
      s.band = s.y_ok && (top || bot);
      if (!s.band) begin
         s.dy = '0;
      end else if (top) begin
         rim  = ry_w - s.yl;
         s.dy = rim[RADIUS_BITS-1:0];
      end else begin
         rim  = s.yl - hmr + SIZE_BITS'(1);
         s.dy = rim[RADIUS_BITS-1:0];
      end
      pipe_in[S_BAND] = s;

      // squares
      s     = pipe_ff[S_BAND];
      s.dy2 = SQ_BITS'(s.dy) * SQ_BITS'(s.dy);
      s.ry2 = SQ_BITS'(s.ryc) * SQ_BITS'(s.ryc);
      s.rx2 = SQ_BITS'(s.rxc) * SQ_BITS'(s.rxc);
      pipe_in[S_SQR] = s;

      // dy never exceeds ry inside the band
      s      = pipe_ff[S_SQR];
      s.diff = s.ry2 - s.dy2;
      pipe_in[S_DIFF] = s;

      // bound for (d*ry)^2; search starts from zero
      s    = pipe_ff[S_DIFF];
      s.t  = PROD_BITS'(s.rx2) * PROD_BITS'(s.diff);
      s.d  = '0;
      s.d2 = '0;
      pipe_in[S_T] = s;

      // largest d with d^2 * ry^2 <= bound, one bit per stage pair, MSB first
      for (int j = 0; j < RADIUS_BITS; j++) begin
         sp = S_SRCH + 2 * j;
         // candidate with the next bit set, square built from shifts
         s    = pipe_ff[sp-1];
         s.c  = s.d | (RADIUS_BITS'(1) << (RADIUS_BITS - 1 - j));
         s.c2 = s.d2 + (SQ_BITS'(s.d) << (RADIUS_BITS - j))
              + (SQ_BITS'(1) << (2 * (RADIUS_BITS - 1 - j)));
         pipe_in[sp] = s;
         // keep the candidate when it still fits
         s = pipe_ff[sp];
         if (PROD_BITS'(s.c2) * PROD_BITS'(s.ry2) <= s.t) begin
            s.d  = s.c;
            s.d2 = s.c2;
         end
         pipe_in[sp+1] = s;
      end

      // row inset and final inside decision
      s   = pipe_ff[S_INS-1];
      ins = s.band ? (s.rxc - s.d) : '0;
      s.in_shape = (fill_a != '0) && s.x_ok && s.y_ok
                 && (s.xl >= SIZE_BITS'(ins))
                 && (s.xl < (rect_width_ff - SIZE_BITS'(ins)));
      pipe_in[S_INS] = s;

      // replace, blend or pass through
      s = pipe_ff[S_INS];
      s.written = s.in_shape;
      if (s.in_shape) begin
         if (fill_a == CH_MAX) begin
            s.col_r = fill_r;
            s.col_g = fill_g;
            s.col_b = fill_b;
         end else begin
            s.col_r = blend8(fill_a, fill_r, s.col_r);
            s.col_g = blend8(fill_a, fill_g, s.col_g);
            s.col_b = blend8(fill_a, fill_b, s.col_b);
         end
         s.col_a = CH_MAX;
      end
      pipe_in[S_OUT] = s;
   end

   // stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int i = 0; i < NSTG; i++) begin
            if (adv[i]) begin
               vld_ff[i] <= vld_in[i];
            end
         end
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      for (int i = 0; i < NSTG; i++) begin
         if (adv[i]) begin
            pipe_ff[i] <= pipe_in[i];
         end
      end
   end

   // result beat
   assign rsp_valid   = vld_ff[S_OUT];
   assign rsp_new_r   = pipe_ff[S_OUT].col_r;
   assign rsp_new_g   = pipe_ff[S_OUT].col_g;
   assign rsp_new_b   = pipe_ff[S_OUT].col_b;
   assign rsp_new_a   = pipe_ff[S_OUT].col_a;
   assign rsp_written = pipe_ff[S_OUT].written;

endmodule

// ===== rtl/rra_check.sv =====
// ----------------------------------------------------------------------------
// rra_check: port-level checks for the rounded-rectangle fill core
// Watches the pixel channels over time; attached to the core by bind.
// ----------------------------------------------------------------------------
module rra_check (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic [rra_pkg::CH_BITS-1:0] rsp_new_r,
   input logic [rra_pkg::CH_BITS-1:0] rsp_new_g,
   input logic [rra_pkg::CH_BITS-1:0] rsp_new_b,
   input logic [rra_pkg::CH_BITS-1:0] rsp_new_a,
   input logic                        rsp_written
);
   import rra_pkg::*;

   // a held result beat stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_new_r)
         && $stable(rsp_new_g) && $stable(rsp_new_b) && $stable(rsp_new_a)
         && $stable(rsp_written))
      else $error("result beat changed while stalled");

   // the pipe drains on leaving reset
   a_reset_empty: assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // with the output free every stage moves, so input is never held
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || !rsp_stall) |-> !req_stall)
      else $error("input stalled while the output is free");

   // a written pixel always comes out opaque
   a_written_opaque: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_written |-> rsp_new_a == CH_MAX)
      else $error("written pixel with alpha other than 255");

endmodule

bind rounded_rect_alpha_fill_core rra_check u_rra_check (.*);
